### hdl/stop_and_wait_arq_endpoint_core_defines.svh
// assertion helpers shared by sawarq_back and sawarq_out
`ifndef STOP_AND_WAIT_ARQ_ENDPOINT_CORE_DEFINES_SVH
`define STOP_AND_WAIT_ARQ_ENDPOINT_CORE_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define SAWARQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never hold outside reset
`define SAWARQ_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### hdl/sawarq_pkg.sv
`default_nettype none
package sawarq_pkg;

	// sizes
	localparam int QUEUE_DEPTH  = 8;
	localparam int PAYLOAD_BITS = 16;
	localparam int SEQ_W        = 8;
	localparam int TIME_W       = 16;
	localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int RUN_LIMIT    = 32;
	localparam int RUN_W        = $clog2(RUN_LIMIT + 1);
	localparam int MAX_RES      = 3;
	localparam int RES_N_W      = 2;
	localparam int OPQ_DEPTH    = 2;
	localparam int OUTQ_DEPTH   = 2;

	localparam logic [TIME_W-1:0] RETRY_RESET = TIME_W'(100);

	// input item kinds
	localparam logic [1:0] KIND_TICK    = 2'd0;
	localparam logic [1:0] KIND_FRAME   = 2'd1;
	localparam logic [1:0] KIND_ENQUEUE = 2'd2;

	// classified operations
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_ACK  = 2'd1;
	localparam logic [1:0] OP_DATA = 2'd2;
	localparam logic [1:0] OP_ENQ  = 2'd3;

	// result kinds
	localparam logic [2:0] RK_SEND     = 3'd0;
	localparam logic [2:0] RK_ACK      = 3'd1;
	localparam logic [2:0] RK_DELIVER  = 3'd2;
	localparam logic [2:0] RK_VALID    = 3'd3;
	localparam logic [2:0] RK_INVALID  = 3'd4;
	localparam logic [2:0] RK_ENQUEUED = 3'd5;
	localparam logic [2:0] RK_FULL     = 3'd6;

	typedef struct packed {
		logic [1:0]              code;
		logic [TIME_W-1:0]       elapsed;
		logic [SEQ_W-1:0]        seq;
		logic [PAYLOAD_BITS-1:0] payload;
		logic                    app_accepts;
	} op_t;

	typedef struct packed {
		logic [2:0]              kind;
		logic [SEQ_W-1:0]        seq;
		logic [PAYLOAD_BITS-1:0] payload;
	} res_t;

	// all results of one item, n = 0 means none
	typedef struct packed {
		logic [RES_N_W-1:0]      n;
		res_t [MAX_RES-1:0]      res;
	} bundle_t;

	typedef struct packed {
		res_t res;
		logic last;
	} out_word_t;

endpackage
`default_nettype wire

### hdl/stop_and_wait_arq_endpoint_core.sv
`default_nettype none
// Stop-and-wait ARQ endpoint. Input words (tick, received frame, enqueue) are pushed
// into a two-entry queue, classified, and carried out by the link engine one per cycle
// unless the result side is still busy; their results (up to three each) leave through
// a two-entry result queue, one per cycle while pop is held, with last_result marking
// the final result of each input word. A word's results share the single result port.
// A tick that gives no result (counting down, or no message held) still goes through
// the engine; kind 3 is dropped on input. The outgoing message queue holds eight messages.
// retry_interval (reset 100) must be written by the user through cfg_valid/cfg_data
// only while no word is in flight; the block does not enforce this. cfg_ready is always high.
module stop_and_wait_arq_endpoint_core
	import sawarq_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	output logic                         full,
	input  wire logic [1:0]              kind,
	input  wire logic [TIME_W-1:0]       elapsed,
	input  wire logic                    frame_is_ack,
	input  wire logic [SEQ_W-1:0]        frame_seq,
	input  wire logic [PAYLOAD_BITS-1:0] payload,
	input  wire logic                    app_accepts,
	output logic                         empty,
	input  wire logic                    pop,
	output logic [2:0]                   result_kind,
	output logic [SEQ_W-1:0]             result_seq,
	output logic [PAYLOAD_BITS-1:0]      result_payload,
	output logic                         last_result,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [TIME_W-1:0]       cfg_data
);

	logic      op_valid;
	op_t       op;
	logic      op_take;
	logic      bundle_ready;
	bundle_t   bundle;
	out_word_t head;

	assign cfg_ready = 1'b1;

	// input side
	sawarq_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.kind         (kind),
		.elapsed      (elapsed),
		.frame_is_ack (frame_is_ack),
		.frame_seq    (frame_seq),
		.payload      (payload),
		.app_accepts  (app_accepts),
		.op_valid     (op_valid),
		.op           (op),
		.op_take      (op_take)
	);

	// link engine
	sawarq_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.op_valid     (op_valid),
		.op           (op),
		.op_take      (op_take),
		.bundle_ready (bundle_ready),
		.bundle       (bundle)
	);

	// result side
	sawarq_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.bundle       (bundle),
		.bundle_ready (bundle_ready),
		.empty        (empty),
		.pop          (pop),
		.head         (head)
	);

	assign result_kind    = head.res.kind;
	assign result_seq     = head.res.seq;
	assign result_payload = head.res.payload;
	assign last_result    = head.last;

endmodule
`default_nettype wire

### hdl/sawarq_front.sv
`default_nettype none
module sawarq_front
	import sawarq_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	output logic                         full,
	input  wire logic [1:0]              kind,
	input  wire logic [TIME_W-1:0]       elapsed,
	input  wire logic                    frame_is_ack,
	input  wire logic [SEQ_W-1:0]        frame_seq,
	input  wire logic [PAYLOAD_BITS-1:0] payload,
	input  wire logic                    app_accepts,
	output logic                         op_valid,
	output op_t                          op,
	input  wire logic                    op_take
);

	op_t        opq_q [OPQ_DEPTH];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       keep;
	logic       wr_en;
	op_t        op_in;

	// classify the incoming word, unused kind is dropped
	always_comb begin
		op_in.elapsed     = elapsed;
		op_in.seq         = frame_seq;
		op_in.payload     = payload;
		op_in.app_accepts = app_accepts;
		op_in.code        = OP_TICK;
		keep              = 1'b1;
		unique case (kind)
			KIND_TICK:    op_in.code = OP_TICK;
			KIND_FRAME:   op_in.code = frame_is_ack ? OP_ACK : OP_DATA;
			KIND_ENQUEUE: op_in.code = OP_ENQ;
			default:      keep = 1'b0;
		endcase
	end

	assign full     = (cnt_q == 2'(OPQ_DEPTH));
	assign wr_en    = push && !full && keep;
	assign op_valid = (cnt_q != 2'd0);
	assign op       = opq_q[rd_q];

	// operation queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wr_q <= ~wr_q;
			if (op_take) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(op_take);
		end
	end

	// operation queue storage
	always_ff @(posedge clk) begin
		if (wr_en) opq_q[wr_q] <= op_in;
	end

endmodule
`default_nettype wire

### hdl/sawarq_back.sv
`default_nettype none
`include "stop_and_wait_arq_endpoint_core_defines.svh"
module sawarq_back
	import sawarq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	input  wire logic [TIME_W-1:0] cfg_data,
	input  wire logic              op_valid,
	input  wire op_t               op,
	output logic                   op_take,
	input  wire logic              bundle_ready,
	output bundle_t                bundle
);

	logic [SEQ_W-1:0]        qseq_q [QUEUE_DEPTH];
	logic [PAYLOAD_BITS-1:0] qpl_q  [QUEUE_DEPTH];
	logic [QPTR_W-1:0]       head_q;
	logic [QCNT_W-1:0]       count_q;
	logic [SEQ_W-1:0]        next_seq_q;
	logic                    ack_vld_q;
	logic [SEQ_W-1:0]        ack_seq_q;
	logic                    hnd_vld_q;
	logic [SEQ_W-1:0]        hnd_seq_q;
	logic [TIME_W-1:0]       countdown_q;
	logic [TIME_W-1:0]       retry_q;
	logic [RUN_W-1:0]        run_q;

	logic [QPTR_W-1:0]       head_d;
	logic [QCNT_W-1:0]       count_d;
	logic [SEQ_W-1:0]        next_seq_d;
	logic                    ack_vld_d;
	logic [SEQ_W-1:0]        ack_seq_d;
	logic                    hnd_vld_d;
	logic [SEQ_W-1:0]        hnd_seq_d;
	logic [TIME_W-1:0]       countdown_d;
	logic [RUN_W-1:0]        run_d;
	logic [RUN_W-1:0]        run_inc;
	logic                    q_we;
	logic [QPTR_W-1:0]       tail;
	logic [QCNT_W:0]         tail_sum;
	logic [SEQ_W-1:0]        head_seq;
	logic [PAYLOAD_BITS-1:0] head_pl;
	logic [QPTR_W-1:0]       head_next;
	logic                    q_empty;

	assign op_take  = op_valid && bundle_ready;
	assign head_seq = qseq_q[head_q];
	assign head_pl  = qpl_q[head_q];
	assign q_empty  = (count_q == '0);
	assign run_inc  = run_q + 1'b1;

	// tail slot and head wrap
	always_comb begin
		tail_sum = (QCNT_W+1)'(head_q) + (QCNT_W+1)'(count_q);
		if (tail_sum >= (QCNT_W+1)'(QUEUE_DEPTH))
			tail_sum = tail_sum - (QCNT_W+1)'(QUEUE_DEPTH);
		tail = tail_sum[QPTR_W-1:0];
		head_next = (head_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	end

	// execute one operation
	always_comb begin
		head_d      = head_q;
		count_d     = count_q;
		next_seq_d  = next_seq_q;
		ack_vld_d   = ack_vld_q;
		ack_seq_d   = ack_seq_q;
		hnd_vld_d   = hnd_vld_q;
		hnd_seq_d   = hnd_seq_q;
		countdown_d = countdown_q;
		run_d       = run_q;
		q_we        = 1'b0;
		bundle      = '0;
		if (op_take) begin
			unique case (op.code)
				OP_TICK: begin
					if (!q_empty) begin
						if (countdown_q > op.elapsed) begin
							countdown_d = countdown_q - op.elapsed;
						end else begin
							bundle.n      = RES_N_W'(1);
							bundle.res[0] = '{kind: RK_SEND, seq: head_seq, payload: head_pl};
							countdown_d   = retry_q;
						end
					end
				end
				OP_ACK: begin
					bundle.n      = RES_N_W'(1);
					bundle.res[0] = '{kind: RK_INVALID, seq: op.seq, payload: '0};
					if (ack_vld_q && op.seq == ack_seq_q) begin
						bundle.res[0].kind = RK_VALID;
					end else if (ack_vld_q && op.seq != ack_seq_q + 1'b1) begin
						bundle.res[0].kind = RK_INVALID;
					end else if (!q_empty && head_seq == op.seq) begin
						// matching ack pops the head, next tick resends at once
						bundle.res[0].kind = RK_VALID;
						head_d      = head_next;
						count_d     = count_q - 1'b1;
						ack_vld_d   = 1'b1;
						ack_seq_d   = op.seq;
						countdown_d = '0;
					end
				end
				OP_DATA: begin
					if (hnd_vld_q && op.seq == hnd_seq_q) begin
						// duplicate, ack it again
						bundle.n      = RES_N_W'(2);
						bundle.res[0] = '{kind: RK_ACK, seq: op.seq, payload: '0};
						bundle.res[1] = '{kind: RK_VALID, seq: op.seq, payload: '0};
					end else if (hnd_vld_q && op.seq != hnd_seq_q + 1'b1 &&
						run_inc < RUN_W'(RUN_LIMIT)) begin
						run_d         = run_inc;
						bundle.n      = RES_N_W'(1);
						bundle.res[0] = '{kind: RK_INVALID, seq: op.seq, payload: '0};
					end else begin
						run_d         = '0;
						bundle.n      = op.app_accepts ? RES_N_W'(3) : RES_N_W'(2);
						bundle.res[0] = '{kind: RK_VALID, seq: op.seq, payload: '0};
						bundle.res[1] = '{kind: RK_DELIVER, seq: op.seq, payload: op.payload};
						bundle.res[2] = '{kind: RK_ACK, seq: op.seq, payload: '0};
						if (op.app_accepts) begin
							hnd_vld_d = 1'b1;
							hnd_seq_d = op.seq;
						end
					end
				end
				OP_ENQ: begin
					bundle.n = RES_N_W'(1);
					if (count_q == QCNT_W'(QUEUE_DEPTH)) begin
						bundle.res[0] = '{kind: RK_FULL, seq: next_seq_q, payload: '0};
					end else begin
						bundle.res[0] = '{kind: RK_ENQUEUED, seq: next_seq_q, payload: '0};
						q_we       = 1'b1;
						count_d    = count_q + 1'b1;
						next_seq_d = next_seq_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// link state and retry register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			next_seq_q  <= '0;
			ack_vld_q   <= 1'b0;
			hnd_vld_q   <= 1'b0;
			countdown_q <= '0;
			run_q       <= '0;
			retry_q     <= RETRY_RESET;
		end else begin
			head_q      <= head_d;
			count_q     <= count_d;
			next_seq_q  <= next_seq_d;
			ack_vld_q   <= ack_vld_d;
			hnd_vld_q   <= hnd_vld_d;
			countdown_q <= countdown_d;
			run_q       <= run_d;
			if (cfg_valid) retry_q <= cfg_data;
		end
	end

	// sequence numbers guarded by their valid bits, and message queue
	always_ff @(posedge clk) begin
		ack_seq_q <= ack_seq_d;
		hnd_seq_q <= hnd_seq_d;
		if (q_we) begin
			qseq_q[tail] <= next_seq_q;
			qpl_q[tail]  <= op.payload;
		end
	end

	`SAWARQ_NEVER(a_count_range, count_q > QCNT_W'(QUEUE_DEPTH), "queue count past depth")
	`SAWARQ_NEVER(a_run_range, run_q >= RUN_W'(RUN_LIMIT), "out-of-order run not cleared")
	`SAWARQ_ASSERT(a_bundle_taken, (bundle.n != '0) |-> bundle_ready, "results dropped")
	`SAWARQ_ASSERT(a_pop_clears, (op_take && op.code == OP_ACK && count_d != count_q) |=> (countdown_q == '0), "retry timer not cleared on pop")

endmodule
`default_nettype wire

### hdl/sawarq_out.sv
`default_nettype none
`include "stop_and_wait_arq_endpoint_core_defines.svh"
module sawarq_out
	import sawarq_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire bundle_t bundle,
	output logic         bundle_ready,
	output logic         empty,
	input  wire logic    pop,
	output out_word_t    head
);

	logic                 bvld_q;
	logic [RES_N_W-1:0]   bn_q;
	logic [RES_N_W-1:0]   bidx_q;
	res_t [MAX_RES-1:0]   bres_q;
	out_word_t            fifo_q [OUTQ_DEPTH];
	logic                 wr_q;
	logic                 rd_q;
	logic [1:0]           cnt_q;
	logic                 pop_now;
	logic                 room;
	logic                 push_w;
	logic                 push_last;
	logic                 load;
	out_word_t            word_in;

	assign empty        = (cnt_q == 2'd0);
	assign pop_now      = pop && !empty;
	assign room         = (cnt_q != 2'(OUTQ_DEPTH)) || pop_now;
	assign push_w       = bvld_q && room;
	assign push_last    = push_w && (bidx_q == bn_q - 1'b1);
	assign bundle_ready = !bvld_q || push_last;
	assign load         = bundle_ready && (bundle.n != '0);
	assign word_in      = '{res: bres_q[bidx_q], last: (bidx_q == bn_q - 1'b1)};
	assign head         = fifo_q[rd_q];

	// result sequencer, one word per cycle while the output queue has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvld_q <= 1'b0;
			bidx_q <= '0;
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (load) begin
				bvld_q <= 1'b1;
				bidx_q <= '0;
			end else if (push_last) begin
				bvld_q <= 1'b0;
			end else if (push_w) begin
				bidx_q <= bidx_q + 1'b1;
			end
			if (push_w) wr_q <= ~wr_q;
			if (pop_now) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push_w) - 2'(pop_now);
		end
	end

	// bundle and output queue storage
	always_ff @(posedge clk) begin
		if (load) begin
			bn_q   <= bundle.n;
			bres_q <= bundle.res;
		end
		if (push_w) fifo_q[wr_q] <= word_in;
	end

	`SAWARQ_NEVER(a_fifo_range, cnt_q > 2'(OUTQ_DEPTH), "output queue overflow")
	`SAWARQ_ASSERT(a_idx_range, bvld_q |-> (bidx_q < bn_q), "result index past bundle")
	`SAWARQ_ASSERT(a_no_overwrite, (load && bvld_q) |-> push_last, "bundle overwritten early")

endmodule
`default_nettype wire

### dv/arq_endpoint_checker.sv
module arq_endpoint_checker
	import sawarq_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic                    full,
	input  logic [1:0]              kind,
	input  logic [TIME_W-1:0]       elapsed,
	input  logic                    frame_is_ack,
	input  logic [SEQ_W-1:0]        frame_seq,
	input  logic [PAYLOAD_BITS-1:0] payload,
	input  logic                    app_accepts,
	input  logic                    empty,
	input  logic                    pop,
	input  logic [2:0]              result_kind,
	input  logic [SEQ_W-1:0]        result_seq,
	input  logic [PAYLOAD_BITS-1:0] result_payload,
	input  logic                    last_result,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [TIME_W-1:0]       cfg_data,
	output int                      mismatch_count,
	output int                      words_due
);
	timeunit 1ns;
	timeprecision 1ps;

	// endpoint state as the checker sees it
	logic [TIME_W-1:0]       retry_period;
	logic [SEQ_W-1:0]        slot_seq [QUEUE_DEPTH];
	logic [PAYLOAD_BITS-1:0] slot_handle [QUEUE_DEPTH];
	logic [QPTR_W-1:0]       head_ptr;
	int                      held;
	logic [SEQ_W-1:0]        next_seq;
	logic                    acked_valid;
	logic [SEQ_W-1:0]        acked_seq;
	logic                    taken_valid;
	logic [SEQ_W-1:0]        taken_seq;
	logic [TIME_W-1:0]       countdown;
	int                      stray_run;

	out_word_t due_words[$];
	out_word_t got_word;
	int        fails;

	function automatic void expect_word(logic [2:0] k, logic [SEQ_W-1:0] s,
			logic [PAYLOAD_BITS-1:0] p);
		out_word_t w;
		w.res.kind    = k;
		w.res.seq     = s;
		w.res.payload = p;
		w.last        = 1'b0;
		due_words.push_back(w);
	endfunction

	// work out the result words of one accepted input word
	function automatic void predict_link(logic [1:0] k, logic [TIME_W-1:0] el, logic is_ack,
			logic [SEQ_W-1:0] s, logic [PAYLOAD_BITS-1:0] pl, logic acc);
		int                base;
		out_word_t         w;
		logic [QPTR_W-1:0] slot;
		base = due_words.size();
		case (k)
			KIND_TICK: begin
				if (held != 0) begin
					if (countdown > el) begin
						countdown = countdown - el;
					end else begin
						expect_word(RK_SEND, slot_seq[head_ptr], slot_handle[head_ptr]);
						countdown = retry_period;
					end
				end
			end
			KIND_FRAME: begin
				if (is_ack) begin
					// ack: duplicate, out of order, empty, wrong head, or pop
					if (acked_valid && s == acked_seq) begin
						expect_word(RK_VALID, s, '0);
					end else if (acked_valid && s != SEQ_W'(acked_seq + 1'b1)) begin
						expect_word(RK_INVALID, s, '0);
					end else if (held == 0 || slot_seq[head_ptr] != s) begin
						expect_word(RK_INVALID, s, '0);
					end else begin
						head_ptr    = head_ptr + 1'b1;
						held        = held - 1;
						expect_word(RK_VALID, s, '0);
						acked_valid = 1'b1;
						acked_seq   = s;
						countdown   = '0;
					end
				end else if (taken_valid && s == taken_seq) begin
					// duplicate data is acked again
					expect_word(RK_ACK, s, '0);
					expect_word(RK_VALID, s, '0);
				end else begin
					if (taken_valid && s != SEQ_W'(taken_seq + 1'b1)) begin
						stray_run = stray_run + 1;
					end
					if (taken_valid && s != SEQ_W'(taken_seq + 1'b1) && stray_run < RUN_LIMIT) begin
						expect_word(RK_INVALID, s, '0);
					end else begin
						stray_run = 0;
						expect_word(RK_VALID, s, '0);
						expect_word(RK_DELIVER, s, pl);
						if (acc) begin
							expect_word(RK_ACK, s, '0);
							taken_valid = 1'b1;
							taken_seq   = s;
						end
					end
				end
			end
			KIND_ENQUEUE: begin
				if (held >= QUEUE_DEPTH) begin
					expect_word(RK_FULL, next_seq, '0);
				end else begin
					slot              = head_ptr + QPTR_W'(held);
					slot_seq[slot]    = next_seq;
					slot_handle[slot] = pl;
					held              = held + 1;
					expect_word(RK_ENQUEUED, next_seq, '0);
					next_seq          = next_seq + 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (due_words.size() > base) begin
			w = due_words[due_words.size() - 1];
			w.last = 1'b1;
			due_words[due_words.size() - 1] = w;
		end
	endfunction

	// watch the three channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_period <= RETRY_RESET;
			head_ptr     <= '0;
			held         <= 0;
			next_seq     <= '0;
			acked_valid  <= 1'b0;
			acked_seq    <= '0;
			taken_valid  <= 1'b0;
			taken_seq    <= '0;
			countdown    <= '0;
			stray_run    <= 0;
			fails        <= 0;
			due_words.delete();
			mismatch_count <= 0;
			words_due      <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				retry_period = cfg_data;
			end
			if (push && !full) begin
				predict_link(kind, elapsed, frame_is_ack, frame_seq, payload, app_accepts);
			end
			// compare the word leaving the block with the oldest one due
			if (pop && !empty) begin
				if (due_words.size() == 0) begin
					$error("result word with none due: result_kind %0d result_seq %0d",
						result_kind, result_seq);
					fails = fails + 1;
				end else begin
					got_word = due_words.pop_front();
					if (result_kind !== got_word.res.kind) begin
						$error("result_kind expected %0d actual %0d", got_word.res.kind, result_kind);
						fails = fails + 1;
					end
					if (result_seq !== got_word.res.seq) begin
						$error("result_seq expected %0d actual %0d", got_word.res.seq, result_seq);
						fails = fails + 1;
					end
					if (result_payload !== got_word.res.payload) begin
						$error("result_payload expected %0h actual %0h", got_word.res.payload,
							result_payload);
						fails = fails + 1;
					end
					if (last_result !== got_word.last) begin
						$error("last_result expected %0d actual %0d", got_word.last, last_result);
						fails = fails + 1;
					end
				end
			end
			mismatch_count <= fails;
			words_due      <= due_words.size();
		end
	end

endmodule

### dv/testbench.sv
module testbench;
	import sawarq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] KIND_UNUSED = 2'd3;

	logic                    clk;
	logic                    arst_n;
	logic                    push;
	logic                    full;
	logic [1:0]              kind;
	logic [TIME_W-1:0]       elapsed;
	logic                    frame_is_ack;
	logic [SEQ_W-1:0]        frame_seq;
	logic [PAYLOAD_BITS-1:0] payload;
	logic                    app_accepts;
	logic                    empty;
	logic                    pop;
	logic [2:0]              result_kind;
	logic [SEQ_W-1:0]        result_seq;
	logic [PAYLOAD_BITS-1:0] result_payload;
	logic                    last_result;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [TIME_W-1:0]       cfg_data;
	int                      mismatch_count;
	int                      words_due;

	// light tracking of link state, used only to shape the stimulus
	logic [SEQ_W-1:0] tx_next;
	int               tx_count;
	logic             rx_valid;
	logic [SEQ_W-1:0] rx_last;
	int               rx_run;
	logic             no_idle;
	int               word_count;
	int               pop_stall;

	stop_and_wait_arq_endpoint_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.kind           (kind),
		.elapsed        (elapsed),
		.frame_is_ack   (frame_is_ack),
		.frame_seq      (frame_seq),
		.payload        (payload),
		.app_accepts    (app_accepts),
		.empty          (empty),
		.pop            (pop),
		.result_kind    (result_kind),
		.result_seq     (result_seq),
		.result_payload (result_payload),
		.last_result    (last_result),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	arq_endpoint_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.kind           (kind),
		.elapsed        (elapsed),
		.frame_is_ack   (frame_is_ack),
		.frame_seq      (frame_seq),
		.payload        (payload),
		.app_accepts    (app_accepts),
		.empty          (empty),
		.pop            (pop),
		.result_kind    (result_kind),
		.result_seq     (result_seq),
		.result_payload (result_payload),
		.last_result    (last_result),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.words_due      (words_due)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// follow the link state that the next word will meet
	function automatic void track_word(logic [1:0] k, logic is_ack, logic [SEQ_W-1:0] s,
			logic acc);
		if (k == KIND_ENQUEUE && tx_count < QUEUE_DEPTH) begin
			tx_count = tx_count + 1;
			tx_next  = tx_next + 1'b1;
		end else if (k == KIND_FRAME && is_ack) begin
			if (tx_count > 0 && s == SEQ_W'(tx_next - tx_count)) begin
				tx_count = tx_count - 1;
			end
		end else if (k == KIND_FRAME && !(rx_valid && s == rx_last)) begin
			if (rx_valid && s != SEQ_W'(rx_last + 1'b1)) begin
				rx_run = rx_run + 1;
			end
			if (!(rx_valid && s != SEQ_W'(rx_last + 1'b1) && rx_run < RUN_LIMIT)) begin
				rx_run = 0;
				if (acc) begin
					rx_valid = 1'b1;
					rx_last  = s;
				end
			end
		end
	endfunction

	// hand one input word to the block and wait until it is taken
	task automatic send_word(logic [1:0] k, logic [TIME_W-1:0] el, logic is_ack,
			logic [SEQ_W-1:0] s, logic [PAYLOAD_BITS-1:0] pl, logic acc);
		push         <= 1'b1;
		kind         <= k;
		elapsed      <= el;
		frame_is_ack <= is_ack;
		frame_seq    <= s;
		payload      <= pl;
		app_accepts  <= acc;
		@(posedge clk);
		while (full) @(posedge clk);
		track_word(k, is_ack, s, acc);
		if (k != KIND_UNUSED) begin
			word_count = word_count + 1;
		end
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// hold the sender until every result word has come out
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (words_due != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_retry(logic [TIME_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly well-formed link traffic with random content, some noise
	task automatic random_word();
		logic [1:0]              k;
		logic [TIME_W-1:0]       el;
		logic                    is_ack;
		logic [SEQ_W-1:0]        s;
		logic [PAYLOAD_BITS-1:0] pl;
		logic                    acc;
		int                      pick;
		el     = TIME_W'($urandom);
		is_ack = 1'($urandom);
		s      = SEQ_W'($urandom);
		pl     = PAYLOAD_BITS'($urandom);
		acc    = 1'($urandom);
		pick   = $urandom_range(0, 99);
		if (pick < 25) begin
			k = KIND_ENQUEUE;
		end else if (pick < 45) begin
			k = KIND_TICK;
			case ($urandom_range(0, 3))
				0: el = TIME_W'($urandom_range(0, 20));
				1: el = '1;
				2: el = '0;
				default: ;
			endcase
		end else if (pick < 65) begin
			k      = KIND_FRAME;
			is_ack = 1'b1;
			case ($urandom_range(0, 9))
				0: ;
				1: s = SEQ_W'(tx_next - tx_count - 1);
				default: s = SEQ_W'(tx_next - tx_count);
			endcase
		end else if (pick < 90) begin
			k      = KIND_FRAME;
			is_ack = 1'b0;
			case ($urandom_range(0, 9))
				0, 1: s = rx_last;
				2: ;
				default: begin
					s   = rx_last + 1'b1;
					acc = ($urandom_range(0, 9) != 0);
				end
			endcase
		end else if (pick < 95) begin
			k = KIND_UNUSED;
		end else begin
			k = 2'($urandom);
		end
		send_word(k, el, is_ack, s, pl, acc);
	endtask

	// one in-order frame, then a row of out-of-order frames up to the run limit
	task automatic stray_frame_run();
		logic [SEQ_W-1:0] s;
		s = rx_valid ? SEQ_W'(rx_last + 1'b1) : SEQ_W'($urandom);
		send_word(KIND_FRAME, TIME_W'($urandom), 1'b0, s, PAYLOAD_BITS'($urandom), 1'b1);
		repeat (RUN_LIMIT) begin
			send_word(KIND_FRAME, TIME_W'($urandom), 1'b0,
				SEQ_W'(rx_last + 2 + $urandom_range(0, 200)),
				PAYLOAD_BITS'($urandom), 1'($urandom));
		end
	endtask

	task automatic random_phase(int n);
		int target;
		target = word_count + n;
		while (word_count < target) begin
			random_word();
		end
	endtask

	// result side: pop with random stall bursts
	initial begin
		pop       = 1'b0;
		pop_stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (no_idle) begin
				pop <= 1'b1;
			end else if (pop_stall > 0) begin
				pop       <= 1'b0;
				pop_stall = pop_stall - 1;
			end else if ($urandom_range(0, 7) == 0) begin
				pop       <= 1'b0;
				pop_stall = $urandom_range(0, 15);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// stimulus and verdict
	initial begin
		arst_n       = 1'b0;
		push         = 1'b0;
		kind         = KIND_TICK;
		elapsed      = '0;
		frame_is_ack = 1'b0;
		frame_seq    = '0;
		payload      = '0;
		app_accepts  = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		tx_next      = '0;
		tx_count     = 0;
		rx_valid     = 1'b0;
		rx_last      = '0;
		rx_run       = 0;
		no_idle      = 1'b0;
		word_count   = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words with the reset retry interval
		send_word(KIND_ENQUEUE, '0, 1'b0, '0, 16'hFFFF, 1'b0);
		send_word(KIND_ENQUEUE, '1, 1'b1, '1, 16'h0000, 1'b1);
		send_word(KIND_TICK, 16'd0, 1'b0, '0, '0, 1'b0);
		send_word(KIND_TICK, 16'hFFFF, 1'b1, '1, '1, 1'b1);
		send_word(KIND_TICK, 16'd1, 1'b0, '0, '0, 1'b0);
		// ack of the wrong head, head, duplicate, out of order, last, empty queue
		send_word(KIND_FRAME, '0, 1'b1, 8'd1, '0, 1'b0);
		send_word(KIND_FRAME, '0, 1'b1, 8'd0, '0, 1'b0);
		send_word(KIND_FRAME, '0, 1'b1, 8'd0, '0, 1'b0);
		send_word(KIND_FRAME, '0, 1'b1, 8'd5, '0, 1'b0);
		send_word(KIND_FRAME, '0, 1'b1, 8'd1, '0, 1'b0);
		send_word(KIND_FRAME, '0, 1'b1, 8'd2, '0, 1'b0);
		send_word(KIND_TICK, 16'd0, 1'b0, '0, '0, 1'b0);
		// data: refused by the application, accepted, duplicate, wrap, out of order
		send_word(KIND_FRAME, '0, 1'b0, 8'd0, 16'h1234, 1'b0);
		send_word(KIND_FRAME, '0, 1'b0, 8'd255, 16'hFFFF, 1'b1);
		send_word(KIND_FRAME, '0, 1'b0, 8'd255, 16'h0000, 1'b1);
		send_word(KIND_FRAME, '0, 1'b0, 8'd0, 16'hA5A5, 1'b1);
		send_word(KIND_FRAME, '0, 1'b0, 8'd7, 16'h5A5A, 1'b1);
		send_word(KIND_UNUSED, '1, 1'b1, '1, '1, 1'b1);
		// fill the outgoing queue and overflow it once
		repeat (QUEUE_DEPTH + 1) begin
			send_word(KIND_ENQUEUE, TIME_W'($urandom), 1'b0, SEQ_W'($urandom),
				PAYLOAD_BITS'($urandom), 1'b0);
		end

		drain();
		write_retry('0);
		random_phase(140);
		stray_frame_run();

		drain();
		write_retry('1);
		random_phase(130);

		drain();
		write_retry(TIME_W'($urandom_range(1, 300)));
		no_idle = 1'b1;
		random_phase(130);

		drain();
		repeat (12) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
